// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the back part of the sequence checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge outside reset.
`define ASSERT_RST(lbl, clk, rst, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst) prop) \
        else $error("ursc: property violated");

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst) !(cond)) \
        else $error("ursc: forbidden condition seen");

`endif

// ===== hw/rtl/ursc_pkg.sv =====
// Types and constants shared by the sequence checker modules.
`default_nettype none

package ursc_pkg;

    localparam logic [2:0] CMD_DATA    = 3'd0;
    localparam logic [2:0] CMD_REPORT  = 3'd1;
    localparam logic [2:0] CMD_START   = 3'd2;
    localparam logic [2:0] CMD_CLEAR   = 3'd3;
    localparam logic [2:0] CMD_UNKNOWN = 3'd4;
    localparam logic [2:0] CMD_EMPTY   = 3'd5;

    localparam logic [1:0] REG_MAGIC       = 2'd0;
    localparam logic [1:0] REG_VERSION     = 2'd1;
    localparam logic [1:0] REG_MAX_PAYLOAD = 2'd2;

    localparam logic [31:0] MAGIC_RESET       = 32'd0;
    localparam logic [15:0] VERSION_RESET     = 16'd1;
    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1472;

    localparam logic [15:0] HDR_BYTES   = 16'd20;
    localparam logic [15:0] START_BYTES = 16'd32;
    localparam logic [31:0] MIN_SIZE    = 32'd20;

    localparam int USEC_W = 20;
    localparam logic [USEC_W-1:0] USEC_PER_SEC = 20'd1000000;

    localparam int DVD_W = 32 + USEC_W;
    localparam int CNT_W = $clog2(DVD_W + 1);

    localparam int QDEPTH = 2;
    localparam int QAW    = $clog2(QDEPTH);

    typedef enum logic [2:0] {
        ACT_IGNORE,
        ACT_BAD,
        ACT_DATA,
        ACT_REPORT,
        ACT_CLEAR
    } act_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_LOAD,
        ST_DIV
    } back_state_t;

    typedef struct packed {
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] max_payload;
    } cfg_t;

    typedef struct packed {
        act_t        act;
        logic [31:0] seq;
        logic [15:0] len;
        logic [31:0] now;
    } work_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ursc_front.sv =====
// Front part: validates each header word and classifies it into a queued action.
`default_nettype none

module ursc_front (
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          command,
    input  logic [31:0]         magic,
    input  logic [15:0]         version,
    input  logic [31:0]         seq_number,
    input  logic [31:0]         declared_length,
    input  logic [15:0]         datagram_len,
    input  logic [31:0]         now_us,
    input  logic [31:0]         start_count,
    input  logic [31:0]         start_size,
    input  ursc_pkg::cfg_t      cfg,
    input  ursc_pkg::q_stat_t   q_stat,
    output logic                q_push,
    output ursc_pkg::work_t     q_word
);
    import ursc_pkg::*;

    logic hdr_bad;
    logic start_bad;
    act_t act;

    assign hdr_bad = (datagram_len < HDR_BYTES) || (magic != cfg.magic)
                     || (version != cfg.version)
                     || (declared_length != {16'd0, datagram_len});

    assign start_bad = (datagram_len < START_BYTES) || (start_count == 32'd0)
                       || (start_size < MIN_SIZE) || (start_size > {16'd0, cfg.max_payload});

    always_comb
    begin
        act = ACT_BAD;
        if (command == CMD_EMPTY || hdr_bad)
        begin
            act = ACT_BAD;
        end
        else
        begin
            case (command)
                CMD_DATA:    act = ACT_DATA;
                CMD_REPORT:  act = ACT_REPORT;
                CMD_START:   act = start_bad ? ACT_BAD : ACT_IGNORE;
                CMD_CLEAR:   act = ACT_CLEAR;
                CMD_UNKNOWN: act = ACT_BAD;
                default:     act = ACT_BAD;
            endcase
        end
    end

    assign in_ready   = !q_stat.full;
    assign q_push     = in_valid && !q_stat.full;
    assign q_word.act = act;
    assign q_word.seq = seq_number;
    assign q_word.len = datagram_len;
    assign q_word.now = now_us;

endmodule

`default_nettype wire

// ===== hw/rtl/ursc_fifo.sv =====
// Short queue of classified words between the front and back parts.
`default_nettype none

module ursc_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ursc_pkg::work_t     push_word,
    input  logic                pop,
    output ursc_pkg::work_t     head,
    output ursc_pkg::q_stat_t   stat
);
    import ursc_pkg::*;

    work_t           entry_reg [QDEPTH];
    logic [QAW-1:0]  wr_ptr_reg;
    logic [QAW-1:0]  wr_ptr_next;
    logic [QAW-1:0]  rd_ptr_reg;
    logic [QAW-1:0]  rd_ptr_next;
    logic [QAW:0]    count_reg;
    logic [QAW:0]    count_next;

    always_comb
    begin
        wr_ptr_next = push ? QAW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? QAW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = (QAW + 1)'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = (QAW + 1)'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_word;
        end
    end

    assign head       = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (QAW + 1)'(QDEPTH));
    assign stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/ursc_div.sv =====
// Shift-subtract divider that yields the low 32 bits of the quotient, one bit a cycle.
`default_nettype none

module ursc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ursc_pkg::DVD_W-1:0]  dividend,
    input  logic [31:0]                 divisor,
    output logic                        done,
    output logic [31:0]                 quotient
);
    import ursc_pkg::*;

    logic [DVD_W-1:0] dvd_reg;
    logic [31:0]      rem_reg;
    logic [31:0]      quo_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [32:0]      trial;
    logic [32:0]      diff;
    logic             take;

    assign trial = {rem_reg, dvd_reg[DVD_W-1]};
    assign diff  = trial - {1'b0, divisor};
    assign take  = (trial >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DVD_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= CNT_W'(cnt_reg - 1'b1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= take ? diff[31:0] : trial[31:0];
            quo_reg <= {quo_reg[30:0], take};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/ursc_back.sv =====
// Back part: carries out queued actions, keeps the statistics and builds report words.
`default_nettype none

`include "assert_macros.svh"

module ursc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ursc_pkg::q_stat_t   q_stat,
    input  ursc_pkg::work_t     q_head,
    output logic                q_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [31:0]         packets_seen,
    output logic [31:0]         bytes_seen,
    output logic [31:0]         missing_count,
    output logic [31:0]         malformed_count,
    output logic [31:0]         reordered_count,
    output logic [31:0]         elapsed_time,
    output logic [31:0]         rate_bps
);
    import ursc_pkg::*;

    back_state_t      state_reg;
    back_state_t      state_next;

    logic [31:0]      packet_total_reg;
    logic [31:0]      packet_total_next;
    logic [31:0]      byte_total_reg;
    logic [31:0]      byte_total_next;
    logic [31:0]      gap_total_reg;
    logic [31:0]      gap_total_next;
    logic [31:0]      bad_total_reg;
    logic [31:0]      bad_total_next;
    logic [31:0]      late_total_reg;
    logic [31:0]      late_total_next;
    logic [31:0]      expected_seq_reg;
    logic [31:0]      expected_seq_next;
    logic [31:0]      first_arrival_reg;
    logic [31:0]      first_arrival_next;
    logic [31:0]      last_arrival_reg;
    logic [31:0]      last_arrival_next;
    logic             has_started_reg;
    logic             has_started_next;

    logic [31:0]      el_reg;
    logic [DVD_W-1:0] product_reg;

    logic             out_valid_reg;
    logic [31:0]      packets_seen_reg;
    logic [31:0]      bytes_seen_reg;
    logic [31:0]      missing_count_reg;
    logic [31:0]      malformed_count_reg;
    logic [31:0]      reordered_count_reg;
    logic [31:0]      elapsed_time_reg;
    logic [31:0]      rate_bps_reg;

    logic             head_is_report;
    logic             can_pop;
    logic [31:0]      el_cur;
    logic [31:0]      seq_diff;
    logic             load_now;
    logic             load_div;
    logic             div_start;
    logic             div_done;
    logic [31:0]      div_quo;

    assign head_is_report = (q_head.act == ACT_REPORT);
    assign can_pop  = !q_stat.empty && (!head_is_report || !out_valid_reg);
    assign el_cur   = has_started_reg ? (last_arrival_reg - first_arrival_reg) : 32'd0;
    assign seq_diff = q_head.seq - expected_seq_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (can_pop && head_is_report && el_cur != 32'd0)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_LOAD;
            ST_LOAD: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop     = 1'b0;
        load_now  = 1'b0;
        load_div  = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                q_pop    = can_pop;
                load_now = can_pop && head_is_report && el_cur == 32'd0;
            end
            ST_MUL:  q_pop = 1'b0;
            ST_LOAD: div_start = 1'b1;
            ST_DIV:  load_div = div_done;
            default: q_pop = 1'b0;
        endcase
    end

    always_comb
    begin
        packet_total_next  = packet_total_reg;
        byte_total_next    = byte_total_reg;
        gap_total_next     = gap_total_reg;
        bad_total_next     = bad_total_reg;
        late_total_next    = late_total_reg;
        expected_seq_next  = expected_seq_reg;
        first_arrival_next = first_arrival_reg;
        last_arrival_next  = last_arrival_reg;
        has_started_next   = has_started_reg;
        if (q_pop)
        begin
            case (q_head.act)
                ACT_BAD: bad_total_next = bad_total_reg + 32'd1;
                ACT_DATA:
                begin
                    if (!has_started_reg)
                    begin
                        has_started_next   = 1'b1;
                        first_arrival_next = q_head.now;
                        expected_seq_next  = q_head.seq + 32'd1;
                    end
                    else if (!seq_diff[31])
                    begin
                        gap_total_next    = gap_total_reg + seq_diff;
                        expected_seq_next = q_head.seq + 32'd1;
                    end
                    else
                    begin
                        late_total_next = late_total_reg + 32'd1;
                    end
                    last_arrival_next = q_head.now;
                    packet_total_next = packet_total_reg + 32'd1;
                    byte_total_next   = byte_total_reg + {16'd0, q_head.len};
                end
                ACT_CLEAR:
                begin
                    packet_total_next  = '0;
                    byte_total_next    = '0;
                    gap_total_next     = '0;
                    bad_total_next     = '0;
                    late_total_next    = '0;
                    expected_seq_next  = '0;
                    first_arrival_next = '0;
                    last_arrival_next  = '0;
                    has_started_next   = 1'b0;
                end
                default: bad_total_next = bad_total_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            packet_total_reg  <= '0;
            byte_total_reg    <= '0;
            gap_total_reg     <= '0;
            bad_total_reg     <= '0;
            late_total_reg    <= '0;
            expected_seq_reg  <= '0;
            first_arrival_reg <= '0;
            last_arrival_reg  <= '0;
            has_started_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            packet_total_reg  <= packet_total_next;
            byte_total_reg    <= byte_total_next;
            gap_total_reg     <= gap_total_next;
            bad_total_reg     <= bad_total_next;
            late_total_reg    <= late_total_next;
            expected_seq_reg  <= expected_seq_next;
            first_arrival_reg <= first_arrival_next;
            last_arrival_reg  <= last_arrival_next;
            has_started_reg   <= has_started_next;
            if (load_now || load_div)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && head_is_report)
        begin
            el_reg <= el_cur;
        end
        if (state_reg == ST_MUL)
        begin
            product_reg <= DVD_W'(byte_total_reg) * DVD_W'(USEC_PER_SEC);
        end
        if (load_now || load_div)
        begin
            packets_seen_reg    <= packet_total_reg;
            bytes_seen_reg      <= byte_total_reg;
            missing_count_reg   <= gap_total_reg;
            malformed_count_reg <= bad_total_reg;
            reordered_count_reg <= late_total_reg;
            elapsed_time_reg    <= load_div ? el_reg : el_cur;
            rate_bps_reg        <= load_div ? div_quo : 32'd0;
        end
    end

    ursc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (product_reg),
        .divisor  (el_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign out_valid       = out_valid_reg;
    assign packets_seen    = packets_seen_reg;
    assign bytes_seen      = bytes_seen_reg;
    assign missing_count   = missing_count_reg;
    assign malformed_count = malformed_count_reg;
    assign reordered_count = reordered_count_reg;
    assign elapsed_time    = elapsed_time_reg;
    assign rate_bps        = rate_bps_reg;

    `ASSERT_RST(a_pop_only_idle, clk, rst_n, q_pop |-> (state_reg == ST_IDLE))
    `ASSERT_RST(a_pop_not_empty, clk, rst_n, q_pop |-> !q_stat.empty)
    `ASSERT_RST(a_busy_no_out, clk, rst_n, (state_reg != ST_IDLE) |-> !out_valid_reg)
    `ASSERT_RST(a_done_in_div, clk, rst_n, div_done |-> (state_reg == ST_DIV))
    `ASSERT_NEVER(a_start_with_pop, clk, rst_n, div_start && q_pop)

endmodule

`default_nettype wire

// ===== hw/rtl/udp_rx_sequence_checker_top.sv =====
// Top level of the received-packet sequence checker with its register port.
//
//   Port group   Direction  Handshake             Contents
//   in_*         in         in_valid / in_ready   one decoded header word
//   out_*        out        out_valid / out_ready one statistics report word
//   p*           in/out     APB write and read    magic, version, max payload
//
// The back part applies data, start, clear and rejected words in its idle state.
// A report with no elapsed time is loaded from the idle state; any other goes
// through the multiply by one million and the 52-step shift-subtract divider.
// The front accepts one word a cycle while the two-entry queue has room.
// Reset clears the counters and loads the register reset values; no clearing pass.
`default_nettype none

module udp_rx_sequence_checker_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [2:0]  command,
    input  logic [31:0] magic,
    input  logic [15:0] version,
    input  logic [31:0] seq_number,
    input  logic [31:0] declared_length,
    input  logic [15:0] datagram_len,
    input  logic [31:0] now_us,
    input  logic [31:0] start_count,
    input  logic [31:0] start_size,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] packets_seen,
    output logic [31:0] bytes_seen,
    output logic [31:0] missing_count,
    output logic [31:0] malformed_count,
    output logic [31:0] reordered_count,
    output logic [31:0] elapsed_time,
    output logic [31:0] rate_bps
);
    import ursc_pkg::*;

    cfg_t        cfg_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;
    q_stat_t     q_stat;
    logic        q_push;
    logic        q_pop;
    work_t       q_word;
    work_t       q_head;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.magic       <= MAGIC_RESET;
            cfg_reg.version     <= VERSION_RESET;
            cfg_reg.max_payload <= MAX_PAYLOAD_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MAGIC:       cfg_reg.magic       <= pwdata;
                REG_VERSION:     cfg_reg.version     <= pwdata[15:0];
                REG_MAX_PAYLOAD: cfg_reg.max_payload <= pwdata[15:0];
                default:         cfg_reg.magic       <= cfg_reg.magic;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MAGIC:       prdata = cfg_reg.magic;
            REG_VERSION:     prdata = {16'd0, cfg_reg.version};
            REG_MAX_PAYLOAD: prdata = {16'd0, cfg_reg.max_payload};
            default:         prdata = 32'd0;
        endcase
    end

    ursc_front u_front (
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .magic           (magic),
        .version         (version),
        .seq_number      (seq_number),
        .declared_length (declared_length),
        .datagram_len    (datagram_len),
        .now_us          (now_us),
        .start_count     (start_count),
        .start_size      (start_size),
        .cfg             (cfg_reg),
        .q_stat          (q_stat),
        .q_push          (q_push),
        .q_word          (q_word)
    );

    ursc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_word (q_word),
        .pop       (q_pop),
        .head      (q_head),
        .stat      (q_stat)
    );

    ursc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_stat          (q_stat),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .packets_seen    (packets_seen),
        .bytes_seen      (bytes_seen),
        .missing_count   (missing_count),
        .malformed_count (malformed_count),
        .reordered_count (reordered_count),
        .elapsed_time    (elapsed_time),
        .rate_bps        (rate_bps)
    );

endmodule

`default_nettype wire

// ===== bench/ursc_report_monitor.sv =====
`timescale 1ns / 1ps
// Monitor that predicts the statistics reports of the sequence checker and compares them.
module ursc_report_monitor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [2:0]  command,
    input  logic [31:0] magic,
    input  logic [15:0] version,
    input  logic [31:0] seq_number,
    input  logic [31:0] declared_length,
    input  logic [15:0] datagram_len,
    input  logic [31:0] now_us,
    input  logic [31:0] start_count,
    input  logic [31:0] start_size,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] packets_seen,
    input  logic [31:0] bytes_seen,
    input  logic [31:0] missing_count,
    input  logic [31:0] malformed_count,
    input  logic [31:0] reordered_count,
    input  logic [31:0] elapsed_time,
    input  logic [31:0] rate_bps,
    output int          fail_count,
    output int          pending,
    output int          reports_seen
);
    import ursc_pkg::*;

    localparam logic [63:0] USEC_IN_SEC = 64'd1000000;

    typedef struct packed {
        logic [31:0] packets;
        logic [31:0] bytes;
        logic [31:0] missing;
        logic [31:0] malformed;
        logic [31:0] reordered;
        logic [31:0] elapsed;
        logic [31:0] rate;
    } stats_report_t;

    logic [31:0] cfg_magic;
    logic [15:0] cfg_version;
    logic [15:0] cfg_max_payload;

    logic [31:0] pkt_total;
    logic [31:0] byte_total;
    logic [31:0] gap_total;
    logic [31:0] bad_total;
    logic [31:0] late_total;
    logic [31:0] next_seq;
    logic [31:0] first_us;
    logic [31:0] last_us;
    bit          started;

    stats_report_t expected_reports[$];
    int            mismatches;
    int            report_count;

    task automatic clear_counters();
        pkt_total  = '0;
        byte_total = '0;
        gap_total  = '0;
        bad_total  = '0;
        late_total = '0;
        next_seq   = '0;
        first_us   = '0;
        last_us    = '0;
        started    = 1'b0;
    endtask

    task automatic check_field(input string label, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", label, want, got);
            mismatches++;
        end
    endtask

    task automatic predict_word(input logic [2:0] cmd, input logic [31:0] mg,
                                input logic [15:0] ver, input logic [31:0] seq,
                                input logic [31:0] dlen, input logic [15:0] tlen,
                                input logic [31:0] now, input logic [31:0] scount,
                                input logic [31:0] ssize);
        logic [31:0]   diff;
        logic [31:0]   el;
        logic [63:0]   prod;
        stats_report_t rpt;
        if (cmd == CMD_EMPTY)
        begin
            bad_total++;
        end
        else if (tlen < HDR_BYTES || mg != cfg_magic || ver != cfg_version
                 || dlen != {16'd0, tlen})
        begin
            bad_total++;
        end
        else
        begin
            case (cmd)
                CMD_DATA:
                begin
                    if (!started)
                    begin
                        started  = 1'b1;
                        first_us = now;
                        next_seq = seq + 32'd1;
                    end
                    else if (seq == next_seq)
                    begin
                        next_seq = next_seq + 32'd1;
                    end
                    else
                    begin
                        diff = seq - next_seq;
                        if (!diff[31])
                        begin
                            gap_total = gap_total + diff;
                            next_seq  = seq + 32'd1;
                        end
                        else
                        begin
                            late_total++;
                        end
                    end
                    last_us    = now;
                    pkt_total  = pkt_total + 32'd1;
                    byte_total = byte_total + {16'd0, tlen};
                end
                CMD_REPORT:
                begin
                    el = started ? (last_us - first_us) : 32'd0;
                    rpt.rate = '0;
                    if (el != 0)
                    begin
                        prod = {32'd0, byte_total} * USEC_IN_SEC;
                        prod = prod / {32'd0, el};
                        rpt.rate = prod[31:0];
                    end
                    rpt.packets   = pkt_total;
                    rpt.bytes     = byte_total;
                    rpt.missing   = gap_total;
                    rpt.malformed = bad_total;
                    rpt.reordered = late_total;
                    rpt.elapsed   = el;
                    expected_reports.push_back(rpt);
                end
                CMD_START:
                begin
                    if (tlen < START_BYTES || scount == 0 || ssize < MIN_SIZE
                        || ssize > {16'd0, cfg_max_payload})
                        bad_total++;
                end
                CMD_CLEAR:
                begin
                    clear_counters();
                end
                default:
                begin
                    bad_total++;
                end
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        stats_report_t want;
        if (!rst_n)
        begin
            cfg_magic       = MAGIC_RESET;
            cfg_version     = VERSION_RESET;
            cfg_max_payload = MAX_PAYLOAD_RESET;
            clear_counters();
            expected_reports.delete();
            mismatches   = 0;
            report_count = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    $error("stats word arrived with no report pending");
                    mismatches++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    report_count++;
                    check_field("packets_seen", want.packets, packets_seen);
                    check_field("bytes_seen", want.bytes, bytes_seen);
                    check_field("missing_count", want.missing, missing_count);
                    check_field("malformed_count", want.malformed, malformed_count);
                    check_field("reordered_count", want.reordered, reordered_count);
                    check_field("elapsed_time", want.elapsed, elapsed_time);
                    check_field("rate_bps", want.rate, rate_bps);
                end
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_MAGIC:       cfg_magic = pwdata;
                    REG_VERSION:     cfg_version = pwdata[15:0];
                    REG_MAX_PAYLOAD: cfg_max_payload = pwdata[15:0];
                    default:         ;
                endcase
            end
            if (in_valid && in_ready)
                predict_word(command, magic, version, seq_number, declared_length,
                             datagram_len, now_us, start_count, start_size);
        end
        fail_count   <= mismatches;
        pending      <= expected_reports.size();
        reports_seen <= report_count;
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the sequence checker testbench: clock, reset, stimulus and verdict.
module tb_top;
    import ursc_pkg::*;

    localparam logic [2:0] CMD_SPARE6  = 3'd6;
    localparam logic [2:0] CMD_SPARE7  = 3'd7;
    localparam int         IDLE_PCT    = 17;
    localparam int         DRAIN_WAIT  = 100;
    localparam int         PHASE_WORDS = 330;
    localparam int         CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] mg;
        logic [15:0] ver;
        logic [31:0] seq;
        logic [31:0] dlen;
        logic [15:0] tlen;
        logic [31:0] now;
        logic [31:0] scount;
        logic [31:0] ssize;
    } hdr_word_t;

    localparam int HDR_W = $bits(hdr_word_t);

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [2:0]  command;
    logic [31:0] magic;
    logic [15:0] version;
    logic [31:0] seq_number;
    logic [31:0] declared_length;
    logic [15:0] datagram_len;
    logic [31:0] now_us;
    logic [31:0] start_count;
    logic [31:0] start_size;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] packets_seen;
    logic [31:0] bytes_seen;
    logic [31:0] missing_count;
    logic [31:0] malformed_count;
    logic [31:0] reordered_count;
    logic [31:0] elapsed_time;
    logic [31:0] rate_bps;

    int fail_count;
    int pending;
    int reports_seen;
    int cycle_count;
    int words_sent;
    int settings_used;
    bit calm;

    logic [31:0] cur_magic;
    logic [15:0] cur_version;
    logic [15:0] cur_max_payload;
    logic [31:0] seq_next;
    logic [31:0] clock_us;

    udp_rx_sequence_checker_top DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .magic(magic), .version(version), .seq_number(seq_number),
        .declared_length(declared_length), .datagram_len(datagram_len), .now_us(now_us),
        .start_count(start_count), .start_size(start_size),
        .out_valid(out_valid), .out_ready(out_ready),
        .packets_seen(packets_seen), .bytes_seen(bytes_seen),
        .missing_count(missing_count), .malformed_count(malformed_count),
        .reordered_count(reordered_count), .elapsed_time(elapsed_time),
        .rate_bps(rate_bps)
    );

    ursc_report_monitor monitor (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .in_valid(in_valid), .in_ready(in_ready), .command(command),
        .magic(magic), .version(version), .seq_number(seq_number),
        .declared_length(declared_length), .datagram_len(datagram_len), .now_us(now_us),
        .start_count(start_count), .start_size(start_size),
        .out_valid(out_valid), .out_ready(out_ready),
        .packets_seen(packets_seen), .bytes_seen(bytes_seen),
        .missing_count(missing_count), .malformed_count(malformed_count),
        .reordered_count(reordered_count), .elapsed_time(elapsed_time),
        .rate_bps(rate_bps),
        .fail_count(fail_count), .pending(pending), .reports_seen(reports_seen)
    );

    initial clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic hdr_word_t make_word(input logic [2:0] cmd, input logic [31:0] seq,
                                            input logic [15:0] tlen, input logic [31:0] now);
        hdr_word_t w;
        w.cmd    = cmd;
        w.mg     = cur_magic;
        w.ver    = cur_version;
        w.seq    = seq;
        w.tlen   = tlen;
        w.dlen   = {16'd0, tlen};
        w.now    = now;
        w.scount = $urandom;
        w.ssize  = $urandom;
        return w;
    endfunction

    function automatic hdr_word_t next_random_word();
        hdr_word_t   w;
        logic [31:0] s;
        logic [15:0] len;
        int          pick;
        int          sel;
        pick = $urandom_range(99);
        len  = ($urandom_range(9) == 0) ? 16'($urandom_range(20, 65535))
                                        : 16'($urandom_range(20, 1500));
        if ($urandom_range(49) == 0)
            clock_us = $urandom;
        else
            clock_us = clock_us + $urandom_range(0, 4000);
        sel = $urandom_range(99);
        if (sel < 75)
            s = seq_next;
        else if (sel < 85)
            s = seq_next + $urandom_range(1, 20);
        else if (sel < 95)
            s = seq_next - $urandom_range(1, 20);
        else
            s = $urandom;
        if (sel < 85 || sel >= 95)
            seq_next = s + 32'd1;
        w = make_word(CMD_DATA, s, len, clock_us);
        if (pick < 60)
        begin
            w.cmd = CMD_DATA;
        end
        else if (pick < 70)
        begin
            w.cmd = CMD_REPORT;
        end
        else if (pick < 78)
        begin
            w = make_word(CMD_START, $urandom, 16'($urandom_range(28, 100)), $urandom);
            w.scount = ($urandom_range(9) == 0) ? 32'd0 : $urandom_range(1, 1000);
            if ($urandom_range(9) < 7)
                w.ssize = $urandom_range(20, cur_max_payload);
        end
        else if (pick < 80)
        begin
            w.cmd = CMD_CLEAR;
        end
        else if (pick < 84)
        begin
            w = HDR_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom, $urandom});
            w.cmd = CMD_EMPTY;
        end
        else if (pick < 88)
        begin
            sel = $urandom_range(2);
            w.cmd = (sel == 0) ? CMD_UNKNOWN : ((sel == 1) ? CMD_SPARE6 : CMD_SPARE7);
        end
        else
        begin
            w.cmd = 3'($urandom_range(7));
            case ($urandom_range(3))
                0: w.mg = w.mg ^ (32'd1 << $urandom_range(31));
                1: w.ver = w.ver ^ (16'd1 << $urandom_range(15));
                2: w.dlen = w.dlen ^ (32'd1 << $urandom_range(31));
                default:
                begin
                    w.tlen = 16'($urandom_range(0, 19));
                    w.dlen = {16'd0, w.tlen};
                end
            endcase
        end
        return w;
    endfunction

    task automatic send_word(input hdr_word_t w);
        int gaps;
        gaps = 0;
        if (!calm)
            while ($urandom_range(99) < IDLE_PCT)
                gaps++;
        if (gaps > 0)
        begin
            in_valid <= 1'b0;
            repeat (gaps) @(posedge clk);
        end
        in_valid        <= 1'b1;
        command         <= w.cmd;
        magic           <= w.mg;
        version         <= w.ver;
        seq_number      <= w.seq;
        declared_length <= w.dlen;
        datagram_len    <= w.tlen;
        now_us          <= w.now;
        start_count     <= w.scount;
        start_size      <= w.ssize;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic apb_write(input logic [1:0] index, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_registers(input logic [31:0] m, input logic [15:0] v,
                                 input logic [15:0] p);
        cur_magic       = m;
        cur_version     = v;
        cur_max_payload = p;
        apb_write(REG_MAGIC, m);
        apb_write(REG_VERSION, {16'd0, v});
        apb_write(REG_MAX_PAYLOAD, {16'd0, p});
        settings_used++;
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    initial
    begin
        hdr_word_t w;
        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_valid        = 1'b0;
        command         = CMD_DATA;
        magic           = '0;
        version         = '0;
        seq_number      = '0;
        declared_length = '0;
        datagram_len    = '0;
        now_us          = '0;
        start_count     = '0;
        start_size      = '0;
        out_ready       = 1'b0;
        calm            = 1'b0;
        cycle_count     = 0;
        words_sent      = 0;
        settings_used   = 1;
        cur_magic       = MAGIC_RESET;
        cur_version     = VERSION_RESET;
        cur_max_payload = MAX_PAYLOAD_RESET;
        seq_next        = 32'd1000;
        clock_us        = 32'd5000;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the register reset values.
        send_word(make_word(CMD_REPORT, 0, 16'd20, 0));
        send_word(make_word(CMD_DATA, 32'd100, 16'd20, 32'd1000));
        send_word(make_word(CMD_DATA, 32'd101, 16'hFFFF, 32'd2000));
        send_word(make_word(CMD_DATA, 32'd110, 16'd600, 32'd2500));
        send_word(make_word(CMD_DATA, 32'd105, 16'd64, 32'd2600));
        send_word(make_word(CMD_DATA, 32'd111 + 32'h8000_0000, 16'd64, 32'd2700));
        send_word(make_word(CMD_DATA, 32'd111 + 32'h7FFF_FFFF, 16'd64, 32'd2800));
        send_word(make_word(CMD_REPORT, 0, 16'd20, 0));
        w = HDR_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom});
        w.cmd = CMD_EMPTY;
        send_word(w);
        send_word(make_word(CMD_DATA, 32'd7, 16'd19, 32'd3000));
        w = make_word(CMD_DATA, 32'd7, 16'd40, 32'd3000);
        w.mg = ~cur_magic;
        send_word(w);
        w = make_word(CMD_DATA, 32'd7, 16'd40, 32'd3000);
        w.ver = w.ver ^ 16'h8000;
        send_word(w);
        w = make_word(CMD_DATA, 32'd7, 16'd64, 32'd3000);
        w.dlen = w.dlen | 32'h8000_0000;
        send_word(w);
        w = make_word(CMD_START, 0, 16'd32, 0);
        w.scount = 32'd1;
        w.ssize  = 32'd20;
        send_word(w);
        w.tlen = 16'd31;
        w.dlen = 32'd31;
        send_word(w);
        w = make_word(CMD_START, 0, 16'd32, 0);
        w.scount = 32'd0;
        w.ssize  = 32'd100;
        send_word(w);
        w.scount = 32'hFFFF_FFFF;
        w.ssize  = 32'd19;
        send_word(w);
        w.ssize = {16'd0, cur_max_payload} + 32'd1;
        send_word(w);
        w.ssize = {16'd0, cur_max_payload};
        send_word(w);
        send_word(make_word(CMD_UNKNOWN, 0, 16'd20, 0));
        send_word(make_word(CMD_SPARE6, 0, 16'd20, 0));
        send_word(make_word(CMD_SPARE7, 0, 16'd20, 0));
        send_word(make_word(CMD_REPORT, 0, 16'd20, 0));
        send_word(make_word(CMD_CLEAR, 0, 16'd20, 0));
        send_word(make_word(CMD_REPORT, 0, 16'd20, 0));
        send_word(make_word(CMD_DATA, 32'hFFFF_FFFF, 16'd1500, 32'hFFFF_FF00));
        send_word(make_word(CMD_DATA, 32'd0, 16'd1500, 32'h0000_0100));
        send_word(make_word(CMD_REPORT, 0, 16'd20, 0));
        send_word(make_word(CMD_CLEAR, 0, 16'd20, 0));
        send_word(make_word(CMD_DATA, 32'd5, 16'd80, 32'd77));
        send_word(make_word(CMD_REPORT, 0, 16'd20, 0));
        in_valid <= 1'b0;

        for (int phase = 0; phase < 4; phase++)
        begin
            drain();
            case (phase)
                0:       set_registers(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
                1:       set_registers(32'd0, 16'd0, 16'd20);
                default: set_registers($urandom, 16'($urandom_range(65535)),
                                       16'($urandom_range(20, 65535)));
            endcase
            calm <= (phase == 0);
            repeat (PHASE_WORDS)
                send_word(next_random_word());
            in_valid <= 1'b0;
        end

        drain();
        $display("Run covered %0d header words under %0d register settings;", words_sent,
                 settings_used);
        $display("%0d stats reports were compared field by field.", reports_seen);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/ursc_pkg.sv
hw/rtl/ursc_front.sv
hw/rtl/ursc_fifo.sv
hw/rtl/ursc_div.sv
hw/rtl/ursc_back.sv
hw/rtl/udp_rx_sequence_checker_top.sv
bench/ursc_report_monitor.sv
bench/tb_top.sv
